// File: rtl/sng_pkg.sv
// Shared types, constants and helpers for the Sobel gradient and edge thinning block.
package sng_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MIN_SIZE   = 3;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int CFG_W      = 11;
	localparam int ROW_W      = 11;
	localparam int IDX_W      = 2;
	localparam int PIX_W      = 8;
	localparam int MAG_W      = 21;
	localparam int THSQ_W     = 22;
	localparam int ABS_W      = 10;
	localparam int GRAD_W     = 11;
	localparam int SQ_W       = 20;
	localparam int PROD_W     = 36;
	localparam int FRAC_BITS  = 24;
	localparam int NUM_SLOTS  = 3;

	// tan(22.5) and tan(67.5) with a 24-bit fraction
	localparam logic [PROD_W-1:0] TAN_LOW  = PROD_W'(6949350);
	localparam logic [PROD_W-1:0] TAN_HIGH = PROD_W'(40503782);

	localparam logic [CFG_W-1:0]  WIDTH_RST  = CFG_W'(640);
	localparam logic [CFG_W-1:0]  HEIGHT_RST = CFG_W'(480);
	localparam logic [THSQ_W-1:0] THSQ_RST   = THSQ_W'(10000);

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_THRESH = 2'd2;

	// direction sectors
	localparam logic [1:0] SECT_0   = 2'd0;
	localparam logic [1:0] SECT_45  = 2'd1;
	localparam logic [1:0] SECT_90  = 2'd2;
	localparam logic [1:0] SECT_135 = 2'd3;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [1:0]       sector_t;
	typedef logic [1:0]       slot_t;

	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} pix_col_t;

	// [row][col], row 0 on top, col 0 on the left
	typedef logic [2:0][2:0][PIX_W-1:0] pix_win_t;

	typedef struct packed {
		sector_t sector;
		mag_t    mag;
	} mag_word_t;

	typedef struct packed {
		mag_t    top;
		mag_t    mid;
		sector_t sect;
		mag_t    bot;
	} mag_col_t;

	// per-request tag carried down the pipeline
	typedef struct packed {
		logic             g;
		logic             t;
		logic             gtop;
		logic             gbot;
		logic             gfirst;
		logic             glast;
		logic             tborder;
		logic             tlast;
		logic [COL_W-1:0] gc;
		slot_t            mslot;
		slot_t            pslot;
	} tag_t;

	// step a three-row ring index
	function automatic slot_t slot_next(input slot_t s);
		slot_t r;
		r = (s == 2'd2) ? 2'd0 : s + 2'd1;
		return r;
	endfunction

endpackage

// File: rtl/sng_ram.sv
// Generic single-write, single-read line memory with registered read data.
module sng_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, hold data while stalled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/sng_grad.sv
// Sobel gradient arithmetic: 3x3 window to squared magnitude and direction sector.
module sng_grad (
	input  logic               clk,
	input  logic               adv,
	input  sng_pkg::pix_win_t  win,
	output sng_pkg::mag_t      mag,
	output sng_pkg::sector_t   sector
);

	import sng_pkg::*;

	logic [ABS_W-1:0]         sum_l, sum_r, sum_t, sum_b;
	logic signed [GRAD_W-1:0] gx_d, gy_d;
	logic signed [GRAD_W-1:0] gx_s3, gy_s3;
	logic [GRAD_W-1:0]        ngx, ngy;
	logic [ABS_W-1:0]         ax, ay;
	logic [SQ_W-1:0]          sqx_s4, sqy_s4;
	logic [PROD_W-1:0]        lo_s4, hi_s4;
	logic [ABS_W-1:0]         ay_s4;
	logic                     zero_s4, same_s4;
	logic [PROD_W-1:0]        lhs;

	// column and row sums of the kernel
	always_comb begin
		sum_l = {2'b0, win[0][0]} + {1'b0, win[1][0], 1'b0} + {2'b0, win[2][0]};
		sum_r = {2'b0, win[0][2]} + {1'b0, win[1][2], 1'b0} + {2'b0, win[2][2]};
		sum_t = {2'b0, win[0][0]} + {1'b0, win[0][1], 1'b0} + {2'b0, win[0][2]};
		sum_b = {2'b0, win[2][0]} + {1'b0, win[2][1], 1'b0} + {2'b0, win[2][2]};
		gx_d  = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
		gy_d  = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s3 <= gx_d;
			gy_s3 <= gy_d;
		end
	end

	// absolute values
	always_comb begin
		ngx = -gx_s3;
		ngy = -gy_s3;
		ax  = gx_s3[GRAD_W-1] ? ngx[ABS_W-1:0] : gx_s3[ABS_W-1:0];
		ay  = gy_s3[GRAD_W-1] ? ngy[ABS_W-1:0] : gy_s3[ABS_W-1:0];
	end

	// squares and slope products
	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s4  <= ax * ax;
			sqy_s4  <= ay * ay;
			lo_s4   <= PROD_W'(ax) * TAN_LOW;
			hi_s4   <= PROD_W'(ax) * TAN_HIGH;
			ay_s4   <= ay;
			zero_s4 <= (gx_s3 == '0) || (gy_s3 == '0);
			same_s4 <= (gx_s3[GRAD_W-1] == gy_s3[GRAD_W-1]);
		end
	end

	assign mag = MAG_W'(sqx_s4) + MAG_W'(sqy_s4);
	assign lhs = PROD_W'({ay_s4, FRAC_BITS'(0)});

	// pick the sector from the slope and the signs
	always_comb begin
		priority if (zero_s4) begin
			sector = SECT_0;
		end else if (same_s4) begin
			if (lhs <= lo_s4) begin
				sector = SECT_0;
			end else if (lhs <= hi_s4) begin
				sector = SECT_45;
			end else begin
				sector = SECT_90;
			end
		end else begin
			if (lhs >= hi_s4) begin
				sector = SECT_90;
			end else if (lhs >= lo_s4) begin
				sector = SECT_135;
			end else begin
				sector = SECT_0;
			end
		end
	end

endmodule

// File: rtl/sobel_gradient_nonmax_suppression.sv
// Top level: streaming 3x3 Sobel gradient with non-maximum suppression.
//
// Usage:
//   Input channel (in_valid / in_stall, pixel, pad) takes grey pixels in raster
//   order; after the W*H pixels of a frame, 2W+2 flush requests (pad=1) drain it.
//   A pad request inside the frame is dropped without effect.
//   Output channel (out_valid / out_stall, edge_res, frame_end) gives one
//   request per pixel, starting once 2W+2 requests of the frame are in;
//   frame_end marks the last pixel of the frame. Border pixels read 0.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes width,
//   height (both clamped to 3..1024 and restarting the frame) and threshold;
//   write it only while the block is idle. cfg_ready is always high.
// Timing:
//   One input request per cycle while in_stall is low. A result is registered
//   through the pipeline stages and then enters the output queue. The line memories
//   are read once per cycle unless stalled, at the input or gradient column.
// Stall and reset:
//   A two-entry output queue separates the sides; in_stall rises only when it
//   is full, and the whole pipeline holds. Reset selects 640x480, threshold 100,
//   and empties pipeline and queue; line memories need no clearing.
module sobel_gradient_nonmax_suppression (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [sng_pkg::PIX_W-1:0]  pixel,
	input  logic                       pad,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       edge_res,
	output logic                       frame_end,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [sng_pkg::IDX_W-1:0]  cfg_index,
	input  logic [sng_pkg::CFG_W-1:0]  cfg_data
);

	import sng_pkg::*;

	// configuration
	logic [CFG_W-1:0]  fw_q, fh_q, cfg_clamp;
	logic [THSQ_W-1:0] thsq_q;
	logic              cfg_we, restart;

	// stream position counters
	logic [ROW_W-1:0] row_q, gr_q, tr_q;
	logic [COL_W-1:0] col_q, gc_q, tc_q;
	slot_t            pslot_q, mslot_q;

	logic adv, acc, eff, in_frame, gstart, tstart, period_end;
	tag_t tag_d, tag_s1, tag_s2, tag_s3, tag_s4;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// pixel path
	pix_t     pix_s1;
	pix_t     pix_rd [NUM_SLOTS];
	pix_col_t fresh, pcol_l_q, pcol_m_q, col_l, col_r;
	pix_win_t win_d, win_s2;

	// magnitude path
	mag_t      mag_s4;
	sector_t   sector_s4;
	mag_word_t mag_rd [NUM_SLOTS];
	mag_word_t mag_wr;
	mag_col_t  mfresh, mcol_l_q, mcol_m_q;
	mag_t      a_d, b_d, m_s5, a_s5, b_s5;
	logic      bord_s5, last_s5, edge_d;

	// output queue
	logic [1:0] res_q [2];
	logic       wr_ptr_q, rd_ptr_q, push, pop;
	logic [1:0] cnt_q;

	// substitute reflected rows at the top and bottom of the frame
	function automatic pix_col_t fix_rows(input pix_col_t c, input logic top, input logic bot);
		pix_col_t r;
		r     = c;
		r.top = top ? c.bot : c.top;
		r.bot = bot ? c.top : c.bot;
		return r;
	endfunction

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign restart   = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

	always_comb begin
		cfg_clamp = cfg_data;
		if (cfg_data < CFG_W'(MIN_SIZE)) begin
			cfg_clamp = CFG_W'(MIN_SIZE);
		end else if (cfg_data > CFG_W'(MAX_WIDTH)) begin
			cfg_clamp = CFG_W'(MAX_WIDTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q   <= WIDTH_RST;
			fh_q   <= HEIGHT_RST;
			thsq_q <= THSQ_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  fw_q   <= cfg_clamp;
				REG_HEIGHT: fh_q   <= cfg_clamp;
				REG_THRESH: thsq_q <= THSQ_W'(cfg_data) * THSQ_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// ---------------- input stage ----------------
	assign adv      = (cnt_q != 2'd2);
	assign in_stall = !adv;
	assign acc      = in_valid && !in_stall;
	assign in_frame = (row_q < fh_q);
	assign eff      = acc && !(in_frame && pad);
	assign gstart   = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
	assign tstart   = (row_q >= ROW_W'(3)) || (row_q == ROW_W'(2) && col_q >= COL_W'(2));
	assign period_end = (row_q == fh_q + ROW_W'(2)) && (col_q == COL_W'(1));

	// build the request tag
	always_comb begin
		tag_d         = '0;
		tag_d.g       = gstart && (gr_q < fh_q);
		tag_d.t       = tstart && (tr_q < fh_q);
		tag_d.gtop    = (gr_q == '0);
		tag_d.gbot    = (gr_q == fh_q - ROW_W'(1));
		tag_d.gfirst  = (gc_q == '0);
		tag_d.glast   = ({1'b0, gc_q} == fw_q - CFG_W'(1));
		tag_d.tborder = (tr_q == '0) || (tc_q == '0) || (tr_q == fh_q - ROW_W'(1))
			|| ({1'b0, tc_q} == fw_q - CFG_W'(1));
		tag_d.tlast   = (tr_q == fh_q - ROW_W'(1)) && ({1'b0, tc_q} == fw_q - CFG_W'(1));
		tag_d.gc      = gc_q;
		tag_d.mslot   = mslot_q;
		tag_d.pslot   = pslot_q;
	end

	// advance input, gradient and result positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			gr_q    <= '0;
			gc_q    <= '0;
			tr_q    <= '0;
			tc_q    <= '0;
			pslot_q <= '0;
			mslot_q <= '0;
		end else if (restart || (eff && period_end)) begin
			row_q   <= '0;
			col_q   <= '0;
			gr_q    <= '0;
			gc_q    <= '0;
			tr_q    <= '0;
			tc_q    <= '0;
			pslot_q <= '0;
			mslot_q <= '0;
		end else if (eff) begin
			if ({1'b0, col_q} == fw_q - CFG_W'(1)) begin
				col_q   <= '0;
				row_q   <= row_q + ROW_W'(1);
				pslot_q <= slot_next(pslot_q);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
			if (gstart) begin
				if ({1'b0, gc_q} == fw_q - CFG_W'(1)) begin
					gc_q    <= '0;
					gr_q    <= gr_q + ROW_W'(1);
					mslot_q <= slot_next(mslot_q);
				end else begin
					gc_q <= gc_q + COL_W'(1);
				end
			end
			if (tstart) begin
				if ({1'b0, tc_q} == fw_q - CFG_W'(1)) begin
					tc_q <= '0;
					tr_q <= tr_q + ROW_W'(1);
				end else begin
					tc_q <= tc_q + COL_W'(1);
				end
			end
		end
	end

	// pixel line ring, one memory per row slot
	for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_pix
		sng_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_pix (
			.clk     (clk),
			.wr_en   (eff && in_frame && (pslot_q == 2'(k))),
			.wr_addr (col_q),
			.wr_data (pixel),
			.rd_en   (adv),
			.rd_addr (col_q),
			.rd_data (pix_rd[k])
		);
	end

	// ---------------- pipeline valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= eff;
			v_s2 <= v_s1 && (tag_s1.g || tag_s1.t);
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4 && tag_s4.t;
		end
	end

	// ---------------- stage 1: pixel window ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_d;
			pix_s1 <= pixel;
		end
	end

	always_comb begin
		fresh.top = pix_rd[slot_next(tag_s1.pslot)];
		fresh.mid = pix_rd[slot_next(slot_next(tag_s1.pslot))];
		fresh.bot = pix_s1;
		col_l = fix_rows(tag_s1.gfirst ? fresh : pcol_l_q, tag_s1.gtop, tag_s1.gbot);
		col_r = fix_rows(tag_s1.glast ? pcol_l_q : fresh, tag_s1.gtop, tag_s1.gbot);
	end

	always_comb begin
		pix_col_t cm;
		cm = fix_rows(pcol_m_q, tag_s1.gtop, tag_s1.gbot);
		win_d[0] = {col_r.top, cm.top, col_l.top};
		win_d[1] = {col_r.mid, cm.mid, col_l.mid};
		win_d[2] = {col_r.bot, cm.bot, col_l.bot};
	end

	// shift the pixel columns on every request
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			pcol_l_q <= pcol_m_q;
			pcol_m_q <= fresh;
		end
	end

	// ---------------- stages 2 to 4: gradient ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2 <= tag_s1;
			win_s2 <= win_d;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	sng_grad u_grad (
		.clk    (clk),
		.adv    (adv),
		.win    (win_s2),
		.mag    (mag_s4),
		.sector (sector_s4)
	);

	// magnitude line ring: read at stage 3, write at stage 4
	assign mag_wr = '{sector: sector_s4, mag: mag_s4};

	for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_mag
		sng_ram #(.DATA_W($bits(mag_word_t)), .DEPTH(MAX_WIDTH)) u_mag (
			.clk     (clk),
			.wr_en   (adv && v_s4 && tag_s4.g && (tag_s4.mslot == 2'(k))),
			.wr_addr (tag_s4.gc),
			.wr_data (mag_wr),
			.rd_en   (adv),
			.rd_addr (tag_s3.gc),
			.rd_data (mag_rd[k])
		);
	end

	// ---------------- stage 4: neighbor select ----------------
	always_comb begin
		mfresh.top  = mag_rd[slot_next(tag_s4.mslot)].mag;
		mfresh.mid  = mag_rd[slot_next(slot_next(tag_s4.mslot))].mag;
		mfresh.sect = mag_rd[slot_next(slot_next(tag_s4.mslot))].sector;
		mfresh.bot  = mag_s4;
	end

	always_comb begin
		unique case (mcol_m_q.sect)
			SECT_45: begin
				a_d = mcol_l_q.top;
				b_d = mfresh.bot;
			end
			SECT_90: begin
				a_d = mcol_m_q.top;
				b_d = mcol_m_q.bot;
			end
			SECT_135: begin
				a_d = mcol_l_q.bot;
				b_d = mfresh.top;
			end
			default: begin
				a_d = mcol_l_q.mid;
				b_d = mfresh.mid;
			end
		endcase
	end

	// shift the magnitude columns on gradient requests
	always_ff @(posedge clk) begin
		if (adv && v_s4 && tag_s4.g) begin
			mcol_l_q <= mcol_m_q;
			mcol_m_q <= mfresh;
		end
	end

	// ---------------- stage 5: edge decision ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s5    <= mcol_m_q.mid;
			a_s5    <= a_d;
			b_s5    <= b_d;
			bord_s5 <= tag_s4.tborder;
			last_s5 <= tag_s4.tlast;
		end
	end

	assign edge_d = !bord_s5 && ({1'b0, m_s5} >= thsq_q) && (m_s5 >= a_s5) && (m_s5 >= b_s5);

	// ---------------- output queue ----------------
	assign push = adv && v_s5;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			res_q[wr_ptr_q] <= {edge_d, last_s5};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign edge_res  = res_q[rd_ptr_q][1];
	assign frame_end = res_q[rd_ptr_q][0];

endmodule
